@@ rtl/touch_swipe_gesture_classifier_macros.svh @@
// ----------------------------------------------------------------------------
// touch_swipe_gesture_classifier assertion macros
// shared concurrent assertion helpers, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef TOUCH_SWIPE_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_SWIPE_GESTURE_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define TSGC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSGC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tsgc_pkg.sv @@
// ----------------------------------------------------------------------------
// tsgc_pkg
// shared types, widths and reset values for the swipe gesture classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsgc_pkg;

  localparam int COORD_WIDTH_DEF = 11;
  localparam int CFG8_W          = 8;
  localparam int SW_W            = 12;
  localparam int OFFSET_W        = 16;
  localparam int NUM_W           = OFFSET_W + 1;
  localparam int DIV_W           = OFFSET_W;
  localparam int DIV_CNT_W       = $clog2(DIV_W);
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = SW_W;

  localparam logic [CFG8_W-1:0] MOVE_THRESHOLD_RST  = 8'd12;
  localparam logic [CFG8_W-1:0] HOME_SWIPE_DIST_RST = 8'd40;
  localparam logic [CFG8_W-1:0] BACK_SWIPE_DIST_RST = 8'd48;
  localparam logic [SW_W-1:0]   SCREEN_WIDTH_RST    = 12'd320;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_RIGHT = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_BACK  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOVE_THRESHOLD  = 4'd0,
    REG_HOME_SWIPE_DIST = 4'd1,
    REG_BACK_SWIPE_DIST = 4'd2,
    REG_ROW_HEIGHT      = 4'd3,
    REG_MAX_ROW         = 4'd4,
    REG_MIRROR_ENABLE   = 4'd5,
    REG_SCREEN_WIDTH    = 4'd6,
    REG_TRACK_BOUND     = 4'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic push;
  } tsgc_cmd_t;

  typedef struct packed {
    logic need_div;
  } tsgc_sts_t;

endpackage

@@ rtl/tsgc_in_if.sv @@
// ----------------------------------------------------------------------------
// tsgc_in_if
// touch sample request channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsgc_in_if #(
  parameter int COORD_WIDTH = tsgc_pkg::COORD_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            pressed;
  logic [COORD_WIDTH-1:0]          touch_x;
  logic [COORD_WIDTH-1:0]          touch_y;
  logic                            on_home;
  logic                            input_blocked;
  logic signed [tsgc_pkg::OFFSET_W-1:0] scroll_offset;

  modport source (
    output valid, pressed, touch_x, touch_y, on_home, input_blocked, scroll_offset,
    input  ready
  );
  modport sink (
    input  valid, pressed, touch_x, touch_y, on_home, input_blocked, scroll_offset,
    output ready
  );
endinterface

@@ rtl/tsgc_out_if.sv @@
// ----------------------------------------------------------------------------
// tsgc_out_if
// gesture result request channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsgc_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic                          row_valid;
  logic [tsgc_pkg::CFG8_W-1:0]   scroll_row;

  modport source (
    output valid, action, row_valid, scroll_row,
    input  ready
  );
  modport sink (
    input  valid, action, row_valid, scroll_row,
    output ready
  );
endinterface

@@ rtl/tsgc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// tsgc_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsgc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tsgc_pkg::CFG_IDX_W-1:0]    index;
  logic [tsgc_pkg::CFG_DATA_W-1:0]   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ rtl/tsgc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsgc_ctrl
// sequencer: sample capture, divider steps and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsgc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tsgc_pkg::tsgc_sts_t sts,
  output tsgc_pkg::tsgc_cmd_t cmd,
  output tsgc_pkg::state_t    state
);

  tsgc_pkg::state_t                 state_r, state_nxt;
  logic [tsgc_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      tsgc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.need_div ? tsgc_pkg::ST_DIV : tsgc_pkg::ST_PUSH;
          cnt_nxt     = '0;
        end
      end
      tsgc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == tsgc_pkg::DIV_CNT_W'(tsgc_pkg::DIV_W - 1)) begin
          state_nxt = tsgc_pkg::ST_PUSH;
        end
      end
      tsgc_pkg::ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = tsgc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tsgc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsgc_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign state     = state_r;

endmodule

@@ rtl/tsgc_dp.sv @@
// ----------------------------------------------------------------------------
// tsgc_dp
// touch tracking state, gesture classification, row divider, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsgc_dp #(
  parameter int COORD_WIDTH = tsgc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tsgc_pkg::tsgc_cmd_t                  cmd,
  output tsgc_pkg::tsgc_sts_t                  sts,
  input  logic                                 cfg_we,
  input  logic [tsgc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsgc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 pressed,
  input  logic [COORD_WIDTH-1:0]               touch_x,
  input  logic [COORD_WIDTH-1:0]               touch_y,
  input  logic                                 on_home,
  input  logic                                 input_blocked,
  input  logic signed [tsgc_pkg::OFFSET_W-1:0] scroll_offset,
  output logic [1:0]                           action,
  output logic                                 row_valid,
  output logic [tsgc_pkg::CFG8_W-1:0]          scroll_row,
  output logic [tsgc_pkg::CFG8_W-1:0]          max_row
);

  localparam int CW   = COORD_WIDTH;
  localparam int W8   = tsgc_pkg::CFG8_W;
  localparam int SW   = tsgc_pkg::SW_W;
  localparam int MW   = ((CW > SW) ? CW : SW) + 2;
  localparam int DW   = tsgc_pkg::DIV_W;
  localparam int NW   = tsgc_pkg::NUM_W;
  localparam logic [MW-1:0] MASK_M = MW'((1 << CW) - 1);

  // configuration
  logic [W8-1:0] move_thr_r, home_dist_r, back_dist_r, row_h_r, max_row_r;
  logic          mirror_r, track_r;
  logic [SW-1:0] screen_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_thr_r  <= tsgc_pkg::MOVE_THRESHOLD_RST;
      home_dist_r <= tsgc_pkg::HOME_SWIPE_DIST_RST;
      back_dist_r <= tsgc_pkg::BACK_SWIPE_DIST_RST;
      row_h_r     <= '0;
      max_row_r   <= '0;
      mirror_r    <= 1'b0;
      screen_w_r  <= tsgc_pkg::SCREEN_WIDTH_RST;
      track_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tsgc_pkg::REG_MOVE_THRESHOLD:  move_thr_r  <= cfg_data[W8-1:0];
        tsgc_pkg::REG_HOME_SWIPE_DIST: home_dist_r <= cfg_data[W8-1:0];
        tsgc_pkg::REG_BACK_SWIPE_DIST: back_dist_r <= cfg_data[W8-1:0];
        tsgc_pkg::REG_ROW_HEIGHT:      row_h_r     <= cfg_data[W8-1:0];
        tsgc_pkg::REG_MAX_ROW:         max_row_r   <= cfg_data[W8-1:0];
        tsgc_pkg::REG_MIRROR_ENABLE:   mirror_r    <= cfg_data[0];
        tsgc_pkg::REG_SCREEN_WIDTH:    screen_w_r  <= cfg_data[SW-1:0];
        tsgc_pkg::REG_TRACK_BOUND:     track_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // tracking state
  logic          active_r, active_nxt;
  logic          moved_r, moved_nxt;
  logic [CW-1:0] start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [CW-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;

  // pending result and divider
  tsgc_pkg::action_t act_r, act_nxt;
  logic              rv_r, rv_nxt;
  logic [W8-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     quo_r, quo_nxt;

  // result register
  logic [1:0]    out_act_r;
  logic          out_rv_r;
  logic [W8-1:0] out_row_r;

  logic signed [MW-1:0] mir_s;
  logic [CW-1:0]        x_m;
  logic signed [CW:0]   step_dx, step_dy, dx, dy, hd_s, bd_s;
  logic [CW-1:0]        abs_sx, abs_sy, ady;
  logic [CW:0]          step_sum;
  logic signed [NW-1:0] num;
  logic                 num_pos, row_en;
  logic [W8:0]          shifted;
  logic [W8+1:0]        trial;
  logic [W8-1:0]        row_clamped;

  // mirror with saturation
  always_comb begin
    mir_s = signed'(MW'(screen_w_r)) - signed'(MW'(1)) - signed'(MW'(touch_x));
    if (!mirror_r) begin
      x_m = touch_x;
    end else if (mir_s < 0) begin
      x_m = '0;
    end else if (mir_s > signed'(MASK_M)) begin
      x_m = MASK_M[CW-1:0];
    end else begin
      x_m = mir_s[CW-1:0];
    end
  end

  always_comb begin
    step_dx  = signed'({1'b0, x_m}) - signed'({1'b0, prev_x_r});
    step_dy  = signed'({1'b0, touch_y}) - signed'({1'b0, prev_y_r});
    abs_sx   = step_dx[CW] ? CW'(-step_dx) : step_dx[CW-1:0];
    abs_sy   = step_dy[CW] ? CW'(-step_dy) : step_dy[CW-1:0];
    step_sum = {1'b0, abs_sx} + {1'b0, abs_sy};
    dx       = signed'({1'b0, prev_x_r}) - signed'({1'b0, start_x_r});
    dy       = signed'({1'b0, prev_y_r}) - signed'({1'b0, start_y_r});
    ady      = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    hd_s     = signed'((CW + 1)'(home_dist_r));
    bd_s     = signed'((CW + 1)'(back_dist_r));
    num      = signed'(NW'(scroll_offset)) + signed'(NW'(row_h_r[W8-1:1]));
    num_pos  = !num[NW-1] && (num != '0);
    row_en   = moved_r && track_r && (row_h_r != '0);
  end

  always_comb begin
    active_nxt  = active_r;
    moved_nxt   = moved_r;
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    act_nxt     = act_r;
    rv_nxt      = rv_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    sts         = '0;
    shifted     = {rem_r, quo_r[DW-1]};
    trial       = {1'b0, shifted} - {2'b00, row_h_r};

    if (cmd.capture) begin
      act_nxt = tsgc_pkg::ACT_NONE;
      rv_nxt  = 1'b0;
      rem_nxt = '0;
      quo_nxt = '0;
      if (!input_blocked) begin
        if (pressed) begin
          if (!active_r) begin
            start_x_nxt = x_m;
            start_y_nxt = touch_y;
            active_nxt  = 1'b1;
            moved_nxt   = 1'b0;
          end else if (step_sum >= (CW + 1)'(move_thr_r)) begin
            moved_nxt = 1'b1;
          end
          prev_x_nxt = x_m;
          prev_y_nxt = touch_y;
        end else if (active_r) begin
          active_nxt = 1'b0;
          rv_nxt     = row_en;
          if (row_en && num_pos) begin
            sts.need_div = 1'b1;
            quo_nxt      = num[DW-1:0];
          end
          if (on_home && (dx > hd_s) && (ady < CW'(home_dist_r))) begin
            act_nxt = tsgc_pkg::ACT_RIGHT;
          end else if (on_home && (dx < -hd_s) && (ady < CW'(home_dist_r))) begin
            act_nxt = tsgc_pkg::ACT_LEFT;
          end else if (!moved_r && !on_home && (dx < -bd_s) &&
                       (ady < CW'(back_dist_r))) begin
            act_nxt = tsgc_pkg::ACT_BACK;
          end
        end
      end
    end else if (cmd.div_step) begin
      // restoring divide, one quotient bit per step
      if (!trial[W8+1]) begin
        rem_nxt = trial[W8-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W8-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
    end
  end

  assign row_clamped = (quo_r > DW'(max_row_r)) ? max_row_r : quo_r[W8-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      moved_r   <= 1'b0;
      start_x_r <= '0;
      start_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
    end else begin
      active_r  <= active_nxt;
      moved_r   <= moved_nxt;
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
      prev_x_r  <= prev_x_nxt;
      prev_y_r  <= prev_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    rv_r  <= rv_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.push) begin
      out_act_r <= act_r;
      out_rv_r  <= rv_r;
      out_row_r <= row_clamped;
    end
  end

  assign action     = out_act_r;
  assign row_valid  = out_rv_r;
  assign scroll_row = out_row_r;
  assign max_row    = max_row_r;

endmodule

@@ rtl/touch_swipe_gesture_classifier.sv @@
// ----------------------------------------------------------------------------
// touch_swipe_gesture_classifier
// classifies polled touch samples into home swipes, back gestures and scroll rows
// ----------------------------------------------------------------------------
// One sample is handled at a time and every sample gives one result. A press,
// hold, blocked sample or release without a divide goes from idle to the push
// state, which loads the result register and frees the input; a release that
// yields a scroll row with a positive numerator first passes the divide state,
// where the 16-step restoring divider forms the row index. A result still held
// by the output side delays the next load until it is taken. The next sample is
// taken as soon as the result is loaded, even while that result still waits on
// the output side. Config writes are always accepted.
`timescale 1ns / 1ps

`include "touch_swipe_gesture_classifier_macros.svh"

module touch_swipe_gesture_classifier #(
  parameter int COORD_WIDTH = tsgc_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tsgc_in_if.sink    in_chan,
  tsgc_out_if.source out_chan,
  tsgc_cfg_if.sink   cfg_chan
);

  tsgc_pkg::tsgc_cmd_t         cmd;
  tsgc_pkg::tsgc_sts_t         sts;
  tsgc_pkg::state_t            state;
  logic [tsgc_pkg::CFG8_W-1:0] max_row;

  assign cfg_chan.ready = 1'b1;

  tsgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd),
    .state     (state)
  );

  tsgc_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_chan.valid),
    .cfg_index     (cfg_chan.index),
    .cfg_data      (cfg_chan.data),
    .pressed       (in_chan.pressed),
    .touch_x       (in_chan.touch_x),
    .touch_y       (in_chan.touch_y),
    .on_home       (in_chan.on_home),
    .input_blocked (in_chan.input_blocked),
    .scroll_offset (in_chan.scroll_offset),
    .action        (out_chan.action),
    .row_valid     (out_chan.row_valid),
    .scroll_row    (out_chan.scroll_row),
    .max_row       (max_row)
  );

  // assertions
  `TSGC_ASSERT_NXT(a_busy_after_request, in_chan.valid && in_chan.ready, !in_chan.ready, "sample taken while busy")
  `TSGC_ASSERT_IMP(a_ready_only_idle, in_chan.ready, state == tsgc_pkg::ST_IDLE, "ready outside idle")
  `TSGC_ASSERT_IMP(a_back_no_row, out_chan.valid && (out_chan.action == tsgc_pkg::ACT_BACK), !out_chan.row_valid, "back gesture with scroll row")
  `TSGC_ASSERT_IMP(a_row_clamped, out_chan.valid && out_chan.row_valid, out_chan.scroll_row <= max_row, "scroll row above max")

endmodule

@@ verif/tsgc_gesture_check.sv @@
// ----------------------------------------------------------------------------
// tsgc_gesture_check
// predicts each gesture result from the sample and register channels and
// compares it field by field with the oldest result still owed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsgc_gesture_check (
  input  logic        clk,
  input  logic        rst_n,
  tsgc_in_if          in_chan,
  tsgc_out_if         out_chan,
  tsgc_cfg_if         cfg_chan,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int CW        = tsgc_pkg::COORD_WIDTH_DEF;
  localparam int W8        = tsgc_pkg::CFG8_W;
  localparam int COORD_MAX = (1 << CW) - 1;

  typedef struct packed {
    tsgc_pkg::action_t  action;
    logic               row_valid;
    logic [W8-1:0]      scroll_row;
  } gesture_t;

  logic [W8-1:0]              move_thr;
  logic [W8-1:0]              home_dist;
  logic [W8-1:0]              back_dist;
  logic [W8-1:0]              row_h;
  logic [W8-1:0]              row_limit;
  logic                       mirror_en;
  logic [tsgc_pkg::SW_W-1:0]  scr_width;
  logic                       track_en;

  logic                       touching;
  logic                       moved;
  logic [CW-1:0]              start_x;
  logic [CW-1:0]              start_y;
  logic [CW-1:0]              last_x;
  logic [CW-1:0]              last_y;

  gesture_t owed_q[$];
  gesture_t got;
  gesture_t want;

  function automatic int magnitude(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic gesture_t classify_sample(
    input logic                                 pressed,
    input logic [CW-1:0]                        raw_x,
    input logic [CW-1:0]                        ty,
    input logic                                 home,
    input logic                                 blocked,
    input logic signed [tsgc_pkg::OFFSET_W-1:0] off
  );
    gesture_t res;
    int       x;
    int       dx;
    int       ady;
    int       num;
    res.action     = tsgc_pkg::ACT_NONE;
    res.row_valid  = 1'b0;
    res.scroll_row = '0;
    if (blocked) return res;
    x = int'(raw_x);
    if (mirror_en) begin
      x = int'(scr_width) - 1 - int'(raw_x);
      if (x < 0) x = 0;
      if (x > COORD_MAX) x = COORD_MAX;
    end
    if (pressed) begin
      if (!touching) begin
        start_x  = x[CW-1:0];
        start_y  = ty;
        touching = 1'b1;
        moved    = 1'b0;
      end else if (magnitude(x - int'(last_x)) + magnitude(int'(ty) - int'(last_y))
                   >= int'(move_thr)) begin
        moved = 1'b1;
      end
      last_x = x[CW-1:0];
      last_y = ty;
      return res;
    end
    if (!touching) return res;
    touching = 1'b0;
    dx  = int'(last_x) - int'(start_x);
    ady = magnitude(int'(last_y) - int'(start_y));
    if (moved && track_en && row_h != 0) begin
      res.row_valid = 1'b1;
      num = int'(off) + int'(row_h) / 2;
      if (num > 0) begin
        num = num / int'(row_h);
        if (num > int'(row_limit)) num = int'(row_limit);
        res.scroll_row = num[W8-1:0];
      end
    end
    if (home && dx > int'(home_dist) && ady < int'(home_dist)) begin
      res.action = tsgc_pkg::ACT_RIGHT;
    end else if (home && dx < -int'(home_dist) && ady < int'(home_dist)) begin
      res.action = tsgc_pkg::ACT_LEFT;
    end else if (!moved && !home && dx < -int'(back_dist) && ady < int'(back_dist)) begin
      res.action = tsgc_pkg::ACT_BACK;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      move_thr  = tsgc_pkg::MOVE_THRESHOLD_RST;
      home_dist = tsgc_pkg::HOME_SWIPE_DIST_RST;
      back_dist = tsgc_pkg::BACK_SWIPE_DIST_RST;
      row_h     = '0;
      row_limit = '0;
      mirror_en = 1'b0;
      scr_width = tsgc_pkg::SCREEN_WIDTH_RST;
      track_en  = 1'b0;
      touching  = 1'b0;
      moved     = 1'b0;
      start_x   = '0;
      start_y   = '0;
      last_x    = '0;
      last_y    = '0;
      owed_q.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (tsgc_pkg::cfg_idx_t'(cfg_chan.index))
          tsgc_pkg::REG_MOVE_THRESHOLD:  move_thr  = cfg_chan.data[W8-1:0];
          tsgc_pkg::REG_HOME_SWIPE_DIST: home_dist = cfg_chan.data[W8-1:0];
          tsgc_pkg::REG_BACK_SWIPE_DIST: back_dist = cfg_chan.data[W8-1:0];
          tsgc_pkg::REG_ROW_HEIGHT:      row_h     = cfg_chan.data[W8-1:0];
          tsgc_pkg::REG_MAX_ROW:         row_limit = cfg_chan.data[W8-1:0];
          tsgc_pkg::REG_MIRROR_ENABLE:   mirror_en = cfg_chan.data[0];
          tsgc_pkg::REG_SCREEN_WIDTH:    scr_width = cfg_chan.data[tsgc_pkg::SW_W-1:0];
          tsgc_pkg::REG_TRACK_BOUND:     track_en  = cfg_chan.data[0];
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        owed_q.push_back(classify_sample(in_chan.pressed, in_chan.touch_x, in_chan.touch_y,
                                         in_chan.on_home, in_chan.input_blocked,
                                         in_chan.scroll_offset));
      end
      if (out_chan.valid && out_chan.ready) begin
        got.action     = tsgc_pkg::action_t'(out_chan.action);
        got.row_valid  = out_chan.row_valid;
        got.scroll_row = out_chan.scroll_row;
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result, action %0d row_valid %0d scroll_row %0d",
                   $time, got.action, got.row_valid, got.scroll_row);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (got.action !== want.action) begin
            $display("%0t: action expected %0d got %0d", $time, want.action, got.action);
            mismatches++;
          end
          if (got.row_valid !== want.row_valid) begin
            $display("%0t: row_valid expected %0d got %0d", $time, want.row_valid,
                     got.row_valid);
            mismatches++;
          end
          if (got.scroll_row !== want.scroll_row) begin
            $display("%0t: scroll_row expected %0d got %0d", $time, want.scroll_row,
                     got.scroll_row);
            mismatches++;
          end
        end
      end
    end
    outstanding = owed_q.size();
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// directed touches for every gesture, mirror saturation and row clamp, then
// random touch sequences under several register settings with bursty requests
// and a stalling result side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int CDW = tsgc_pkg::CFG_DATA_W;

  typedef enum int {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SLOW
  } drain_mode_t;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned samples_sent = 0;
  int          burst_left   = 0;
  drain_mode_t drain_mode   = DRAIN_FREE;
  int          drain_left   = 0;

  tsgc_in_if  in_chan ();
  tsgc_out_if out_chan ();
  tsgc_cfg_if cfg_chan ();

  touch_swipe_gesture_classifier i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  tsgc_gesture_check i_gesture_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_chan    (cfg_chan),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (drain_left == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 2));
      drain_left = $urandom_range(8, 80);
    end else begin
      drain_left--;
    end
    case (drain_mode)
      DRAIN_FREE: out_chan.ready <= 1'b1;
      DRAIN_COIN: out_chan.ready <= 1'($urandom_range(0, 1));
      default:    out_chan.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic program_register(input tsgc_pkg::cfg_idx_t idx,
                                  input logic [CDW-1:0] value);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [7:0] thr, input logic [7:0] home_d,
                               input logic [7:0] back_d, input logic [7:0] rh,
                               input logic [7:0] top_row, input logic mirror,
                               input logic [11:0] width, input logic track);
    program_register(tsgc_pkg::REG_MOVE_THRESHOLD, CDW'(thr));
    program_register(tsgc_pkg::REG_HOME_SWIPE_DIST, CDW'(home_d));
    program_register(tsgc_pkg::REG_BACK_SWIPE_DIST, CDW'(back_d));
    program_register(tsgc_pkg::REG_ROW_HEIGHT, CDW'(rh));
    program_register(tsgc_pkg::REG_MAX_ROW, CDW'(top_row));
    program_register(tsgc_pkg::REG_MIRROR_ENABLE, CDW'(mirror));
    program_register(tsgc_pkg::REG_SCREEN_WIDTH, width);
    program_register(tsgc_pkg::REG_TRACK_BOUND, CDW'(track));
  endtask

  task automatic send_sample(input logic pressed, input logic [10:0] x, input logic [10:0] y,
                             input logic home, input logic blocked,
                             input logic signed [15:0] off);
    @(negedge clk);
    in_chan.valid         <= 1'b1;
    in_chan.pressed       <= pressed;
    in_chan.touch_x       <= x;
    in_chan.touch_y       <= y;
    in_chan.on_home       <= home;
    in_chan.input_blocked <= blocked;
    in_chan.scroll_offset <= off;
    do @(posedge clk); while (!in_chan.ready);
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3:    return 16'(int'($urandom_range(0, 4000)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  // press, a random walk of holds with stray blocked samples, then release
  task automatic random_touch();
    int   x;
    int   y;
    int   dir_x;
    int   reach;
    int   holds;
    logic home;
    home  = 1'($urandom_range(0, 1));
    x     = $urandom_range(0, 2047);
    y     = $urandom_range(0, 2047);
    dir_x = $urandom_range(0, 1) ? 1 : -1;
    reach = ($urandom_range(0, 3) == 0) ? 300 : 40;
    holds = $urandom_range(0, 6);
    send_sample(1'b1, 11'(x), 11'(y), home, 1'b0, pick_offset());
    repeat (holds) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                    11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)), 1'b1,
                    pick_offset());
      end
      x += dir_x * int'($urandom_range(0, reach)) - int'($urandom_range(0, 8));
      y += int'($urandom_range(0, 24)) - 12;
      x  = x < 0 ? 0 : (x > 2047 ? 2047 : x);
      y  = y < 0 ? 0 : (y > 2047 ? 2047 : y);
      send_sample(1'b1, 11'(x), 11'(y), home, 1'b0, pick_offset());
    end
    send_sample(1'b0, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)), home, 1'b0,
                pick_offset());
  endtask

  initial begin
    int unsigned target;
    in_chan.valid         = 1'b0;
    in_chan.pressed       = 1'b0;
    in_chan.touch_x       = '0;
    in_chan.touch_y       = '0;
    in_chan.on_home       = 1'b0;
    in_chan.input_blocked = 1'b0;
    in_chan.scroll_offset = '0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.index        = tsgc_pkg::REG_MOVE_THRESHOLD;
    cfg_chan.data         = '0;
    out_chan.ready        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: idle release, right swipe, left swipe across a blocked sample
    send_sample(1'b0, 11'd0, 11'd0, 1'b0, 1'b0, 16'sd0);
    send_sample(1'b1, 11'd100, 11'd100, 1'b1, 1'b0, 16'sd0);
    send_sample(1'b1, 11'd151, 11'd100, 1'b1, 1'b0, 16'sd0);
    send_sample(1'b0, 11'd0, 11'd0, 1'b1, 1'b0, 16'sd0);
    send_sample(1'b1, 11'd400, 11'd500, 1'b1, 1'b0, 16'sd0);
    send_sample(1'b0, 11'd2047, 11'd2047, 1'b1, 1'b1, -16'sd1);
    send_sample(1'b1, 11'd340, 11'd510, 1'b1, 1'b0, 16'sd0);
    send_sample(1'b0, 11'd0, 11'd0, 1'b1, 1'b0, 16'sh7fff);
    send_sample(1'b1, 11'd0, 11'd0, 1'b0, 1'b0, 16'sd0);
    send_sample(1'b1, 11'd2047, 11'd2047, 1'b0, 1'b0, 16'sd0);
    send_sample(1'b0, 11'd0, 11'd0, 1'b0, 1'b0, 16'sh8000);

    // mirrored, high threshold: back gesture, then a moved touch with a scroll row
    wait_idle();
    load_settings(8'd255, 8'd0, 8'd100, 8'd255, 8'd255, 1'b1, 12'd2048, 1'b1);
    send_sample(1'b1, 11'd100, 11'd50, 1'b0, 1'b0, 16'sd0);
    send_sample(1'b1, 11'd300, 11'd50, 1'b0, 1'b0, 16'sd0);
    send_sample(1'b0, 11'd0, 11'd0, 1'b0, 1'b0, 16'sh8000);
    send_sample(1'b1, 11'd0, 11'd0, 1'b1, 1'b0, 16'sd0);
    send_sample(1'b1, 11'd2047, 11'd300, 1'b1, 1'b0, 16'sd0);
    send_sample(1'b0, 11'd0, 11'd0, 1'b1, 1'b0, 16'sh7fff);

    // zero threshold, mirror saturating at zero, row clamped to zero
    wait_idle();
    load_settings(8'd0, 8'd255, 8'd255, 8'd1, 8'd0, 1'b1, 12'd1, 1'b1);
    send_sample(1'b1, 11'd5, 11'd0, 1'b0, 1'b0, 16'sd0);
    send_sample(1'b1, 11'd5, 11'd0, 1'b0, 1'b0, 16'sd0);
    send_sample(1'b0, 11'd0, 11'd0, 1'b0, 1'b0, 16'sd100);
    send_sample(1'b1, 11'd0, 11'd7, 1'b0, 1'b0, 16'sd0);
    send_sample(1'b1, 11'd0, 11'd7, 1'b0, 1'b0, 16'sd0);
    send_sample(1'b0, 11'd0, 11'd0, 1'b0, 1'b0, -16'sd1);

    for (int phase = 0; phase < 7; phase++) begin
      wait_idle();
      case (phase)
        0: load_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 12'd2048, 1'b1);
        1: load_settings(8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 1'b0, 12'd1, 1'b1);
        2: load_settings(tsgc_pkg::MOVE_THRESHOLD_RST, tsgc_pkg::HOME_SWIPE_DIST_RST,
                         tsgc_pkg::BACK_SWIPE_DIST_RST, 8'd16, 8'd40, 1'b0,
                         tsgc_pkg::SCREEN_WIDTH_RST, 1'b1);
        default: load_settings(pick_level(), pick_level(), pick_level(),
                               ($urandom_range(0, 4) == 0) ? 8'd0 : pick_level(),
                               pick_level(), 1'($urandom_range(0, 1)),
                               ($urandom_range(0, 3) == 0) ? 12'd2048
                                                           : 12'($urandom_range(1, 2048)),
                               $urandom_range(0, 3) != 0);
      endcase
      target = samples_sent + 280;
      while (samples_sent < target) begin
        if ($urandom_range(0, 6) == 0) begin
          send_sample(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                      11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0, 16'($urandom));
        end else begin
          random_touch();
        end
      end
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tsgc_pkg.sv
rtl/tsgc_in_if.sv
rtl/tsgc_out_if.sv
rtl/tsgc_cfg_if.sv
rtl/tsgc_ctrl.sv
rtl/tsgc_dp.sv
rtl/touch_swipe_gesture_classifier.sv
verif/tsgc_gesture_check.sv
verif/tb.sv
